>>> src/llfr_pkg.sv
// ----------------------------------------------------------------------------
// llfr_pkg
// Shared types and constants for the log line field recognizer: field tags,
// level word codes, severity classes and the level word spelling table.
// ----------------------------------------------------------------------------
package llfr_pkg;

  // minimum number of bytes in a valid line, and the width of its counter
  localparam int MIN_LINE_BYTES = 25;
  localparam int LEN_W = $clog2(MIN_LINE_BYTES + 1);
  localparam int NUM_WORDS = 7;

  // field tags
  localparam logic [2:0] TAG_DATE    = 3'd0;
  localparam logic [2:0] TAG_TIME    = 3'd1;
  localparam logic [2:0] TAG_PID     = 3'd2;
  localparam logic [2:0] TAG_LEVEL   = 3'd3;
  localparam logic [2:0] TAG_COMP    = 3'd4;
  localparam logic [2:0] TAG_MSG     = 3'd5;
  localparam logic [2:0] TAG_SEP     = 3'd6;
  localparam logic [2:0] TAG_REJECT  = 3'd7;

  // level word codes
  localparam logic [2:0] LVL_INFO    = 3'd0;
  localparam logic [2:0] LVL_WARN    = 3'd1;
  localparam logic [2:0] LVL_WARNING = 3'd2;
  localparam logic [2:0] LVL_ERROR   = 3'd3;
  localparam logic [2:0] LVL_FATAL   = 3'd4;
  localparam logic [2:0] LVL_DEBUG   = 3'd5;
  localparam logic [2:0] LVL_TRACE   = 3'd6;

  // severity classes
  localparam logic [1:0] SEV_INFO    = 2'd0;
  localparam logic [1:0] SEV_WARNING = 2'd1;
  localparam logic [1:0] SEV_ERROR   = 2'd2;

  // spelling of each level word, padded with zero bytes
  localparam logic [7:0] WORD_TEXT [0:NUM_WORDS-1][0:7] = '{
    '{"I", "N", "F", "O", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"W", "A", "R", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"W", "A", "R", "N", "I", "N", "G", 8'h00},
    '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00},
    '{"F", "A", "T", "A", "L", 8'h00, 8'h00, 8'h00},
    '{"D", "E", "B", "U", "G", 8'h00, 8'h00, 8'h00},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] WORD_LEN [0:NUM_WORDS-1] = '{
    3'd4, 3'd4, 3'd7, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [1:0] WORD_SEV [0:NUM_WORDS-1] = '{
    SEV_INFO, SEV_WARNING, SEV_WARNING, SEV_ERROR, SEV_ERROR, SEV_INFO, SEV_INFO
  };

  // per-byte result from the parser
  typedef struct packed {
    logic [2:0] tag;
    logic       done;
    logic       ok;
    logic [2:0] word;
    logic [1:0] sev;
  } res_t;

  // lowest surviving level word
  function automatic logic [2:0] first_word(input logic [NUM_WORDS-1:0] cand);
    logic [2:0] w;
    w = LVL_INFO;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        w = 3'(i);
      end
    end
    return w;
  endfunction

endpackage

>>> src/llfr_parse.sv
// ----------------------------------------------------------------------------
// llfr_parse
// Per-line layout tracker: holds the phase and field counters of the current
// line, tags each byte and judges the line on its last byte.
// ----------------------------------------------------------------------------
module llfr_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [7:0]        char_byte,
  input  logic              end_of_line,
  output llfr_pkg::res_t    res
);
  import llfr_pkg::*;

  typedef enum logic [3:0] {
    PH_DATE, PH_SEP_A, PH_TIME, PH_SEP_B, PH_PID_FIRST, PH_PID_REST,
    PH_WORD, PH_COMP_FIRST, PH_COMP, PH_AFTER_COLON, PH_MSG
  } phase_t;

  phase_t                 phase, phase_next;
  logic [2:0]             digit_count, digit_count_next;
  logic [LEN_W-1:0]       length_count, length_count_next;
  logic [NUM_WORDS-1:0]   level_candidates, level_candidates_next;
  logic [2:0]             letter_count, letter_count_next;
  logic                   failed_flag, failed_flag_next;

  logic                   is_digit, is_letter, is_space, is_colon, bad;
  logic [NUM_WORDS-1:0]   keep, full;
  logic [2:0]             digits_inc;

  // byte classes
  assign is_digit  = (char_byte >= "0") && (char_byte <= "9");
  assign is_letter = ((char_byte >= "A") && (char_byte <= "Z")) ||
                     ((char_byte >= "a") && (char_byte <= "z"));
  assign is_space  = (char_byte == " ");
  assign is_colon  = (char_byte == ":");
  assign digits_inc = digit_count + 3'd1;

  // letter match against each word, and words complete at this length
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      keep[w] = (letter_count < WORD_LEN[w]) &&
                (WORD_TEXT[w][letter_count] == char_byte);
      full[w] = level_candidates[w] && (WORD_LEN[w] == letter_count);
    end
  end

  // next state and byte tag
  always_comb begin
    phase_next            = phase;
    digit_count_next      = digit_count;
    level_candidates_next = level_candidates;
    letter_count_next     = letter_count;
    failed_flag_next      = failed_flag;
    length_count_next     = length_count;
    bad                   = 1'b0;
    res                   = '0;
    res.tag               = TAG_REJECT;

    if (length_count < LEN_W'(MIN_LINE_BYTES)) begin
      length_count_next = length_count + 1'b1;
    end

    if (!failed_flag) begin
      unique case (phase)
        PH_DATE, PH_TIME: begin
          if (is_digit) begin
            res.tag = (phase == PH_DATE) ? TAG_DATE : TAG_TIME;
            if (digits_inc >= 3'd6) begin
              digit_count_next = '0;
              phase_next = (phase == PH_DATE) ? PH_SEP_A : PH_SEP_B;
            end else begin
              digit_count_next = digits_inc;
            end
          end else begin
            bad = 1'b1;
          end
        end
        PH_SEP_A, PH_SEP_B: begin
          if (is_space) begin
            res.tag = TAG_SEP;
            phase_next = (phase == PH_SEP_A) ? PH_TIME : PH_PID_FIRST;
          end else begin
            bad = 1'b1;
          end
        end
        PH_PID_FIRST: begin
          if (is_digit) begin
            res.tag = TAG_PID;
            phase_next = PH_PID_REST;
          end else begin
            bad = 1'b1;
          end
        end
        PH_PID_REST: begin
          if (is_digit) begin
            res.tag = TAG_PID;
          end else if (is_space) begin
            res.tag = TAG_SEP;
            phase_next = PH_WORD;
          end else begin
            bad = 1'b1;
          end
        end
        PH_WORD: begin
          if (is_letter) begin
            res.tag = TAG_LEVEL;
            if (letter_count == 3'd7) begin
              level_candidates_next = '0;
            end else begin
              level_candidates_next = level_candidates & keep;
              letter_count_next = letter_count + 3'd1;
            end
          end else if (letter_count == 3'd0 || full == '0 || !is_space) begin
            bad = 1'b1;
          end else begin
            level_candidates_next = full;
            res.tag = TAG_SEP;
            phase_next = PH_COMP_FIRST;
          end
        end
        PH_COMP_FIRST: begin
          if (is_colon) begin
            bad = 1'b1;
          end else begin
            res.tag = TAG_COMP;
            phase_next = PH_COMP;
          end
        end
        PH_COMP: begin
          if (is_colon) begin
            res.tag = TAG_SEP;
            phase_next = PH_AFTER_COLON;
          end else begin
            res.tag = TAG_COMP;
          end
        end
        PH_AFTER_COLON: begin
          res.tag = is_space ? TAG_SEP : TAG_MSG;
          phase_next = PH_MSG;
        end
        PH_MSG: begin
          res.tag = TAG_MSG;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        failed_flag_next = 1'b1;
        res.tag = TAG_REJECT;
      end
    end

    // end of line: judge, then clear the per-line state
    if (end_of_line) begin
      res.done = 1'b1;
      if (!failed_flag_next && (phase_next == PH_AFTER_COLON || phase_next == PH_MSG) &&
          length_count_next >= LEN_W'(MIN_LINE_BYTES)) begin
        res.ok   = 1'b1;
        res.word = first_word(level_candidates_next);
        res.sev  = WORD_SEV[res.word];
      end
      phase_next            = PH_DATE;
      digit_count_next      = '0;
      length_count_next     = '0;
      level_candidates_next = '1;
      letter_count_next     = '0;
      failed_flag_next      = 1'b0;
    end
  end

  // per-line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_DATE;
      digit_count      <= '0;
      length_count     <= '0;
      level_candidates <= '1;
      letter_count     <= '0;
      failed_flag      <= 1'b0;
    end else if (en) begin
      phase            <= phase_next;
      digit_count      <= digit_count_next;
      length_count     <= length_count_next;
      level_candidates <= level_candidates_next;
      letter_count     <= letter_count_next;
      failed_flag      <= failed_flag_next;
    end
  end

endmodule

>>> src/llfr_counters.sv
// ----------------------------------------------------------------------------
// llfr_counters
// Line counter and valid-line event counter, both counting from one and
// wrapping at 32 bits.
// ----------------------------------------------------------------------------
module llfr_counters (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        line_end,
  input  logic        line_good,
  output logic [31:0] line_seq,
  output logic [31:0] event_seq
);
  import llfr_pkg::*;

  logic [31:0] line_counter;
  logic [31:0] valid_counter;

  assign line_seq  = line_counter;
  assign event_seq = (line_end && line_good) ? valid_counter : '0;

  // advance on each finished line, and on each valid one
  always_ff @(posedge clk) begin
    if (rst) begin
      line_counter  <= 32'd1;
      valid_counter <= 32'd1;
    end else if (en && line_end) begin
      line_counter <= line_counter + 32'd1;
      if (line_good) begin
        valid_counter <= valid_counter + 32'd1;
      end
    end
  end

endmodule

>>> src/log_line_field_recognizer_core.sv
// ----------------------------------------------------------------------------
// log_line_field_recognizer_core
// Tags each byte of a log line with its field and reports on every line end
// whether the line matched the layout, its level word and severity, a line
// number and a valid-line event number.
//
// Usage:
//   Input channel: char_byte, end_of_line with char_valid / char_stall. A word
//   is taken at a rising edge with char_valid high and char_stall low.
//   Output channel: one result word per input word on result_valid /
//   result_stall, with field_tag, line_done, line_ok, level_word,
//   severity_class, event_number and line_count_out.
//   Path: a word taken lands in the input register, is parsed from it and
//   is captured in the result register, which drives the outputs.
//   Throughput: one byte per cycle while result_stall is low; the per-line
//   parser state is updated from the input register as each word advances.
//   Stall: while result_stall holds a result, the input register keeps its
//   word and char_stall rises once it is full; no word is lost.
//   Reset: rst (synchronous) empties both registers, puts the parser at the
//   start of a line and sets both counters to one.
// ----------------------------------------------------------------------------
module log_line_field_recognizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_byte,
  input  logic        end_of_line,
  input  logic        char_valid,
  output logic        char_stall,
  output logic [2:0]  field_tag,
  output logic        line_done,
  output logic        line_ok,
  output logic [2:0]  level_word,
  output logic [1:0]  severity_class,
  output logic [31:0] event_number,
  output logic [31:0] line_count_out,
  output logic        result_valid,
  input  logic        result_stall
);
  import llfr_pkg::*;

  logic        s0_valid;
  logic [7:0]  s0_byte;
  logic        s0_eol;
  logic        out_free;
  logic        adv;
  res_t        res;
  logic [31:0] cnt_line;
  logic [31:0] cnt_event;

  // handshake: output register frees when empty or being taken
  assign out_free   = !result_valid || !result_stall;
  assign adv        = s0_valid && out_free;
  assign char_stall = s0_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!char_stall) begin
      s0_valid <= char_valid;
    end
    if (!char_stall && char_valid) begin
      s0_byte <= char_byte;
      s0_eol  <= end_of_line;
    end
  end

  llfr_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .char_byte   (s0_byte),
    .end_of_line (s0_eol),
    .res         (res)
  );

  llfr_counters u_counters (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .line_end    (res.done),
    .line_good   (res.ok),
    .line_seq    (cnt_line),
    .event_seq   (cnt_event)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s0_valid;
    end
    if (adv) begin
      field_tag      <= res.tag;
      line_done      <= res.done;
      line_ok        <= res.ok;
      level_word     <= res.word;
      severity_class <= res.sev;
      event_number   <= cnt_event;
      line_count_out <= cnt_line;
    end
  end

  // a good line is always a finished line
  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && line_ok |-> line_done)
    else $error("line_ok without line_done");

  // a rejected or unfinished line carries no level, severity or event
  a_bad_line_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !line_ok |-> level_word == LVL_INFO &&
      severity_class == SEV_INFO && event_number == 32'd0)
    else $error("report fields set on a line that is not good");

  // severity follows the level word
  a_sev_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid && line_ok |-> level_word != 3'd7 &&
      severity_class == WORD_SEV[level_word])
    else $error("severity does not match level word");

  // line counter steps exactly once per finished line
  a_line_step: assert property (@(posedge clk) disable iff (rst)
    adv && s0_eol |=> cnt_line == $past(cnt_line) + 32'd1)
    else $error("line counter did not advance at line end");

endmodule
